>>> hdl/spm_pkg.sv
package spm_pkg;

    // Sizing of the term stores and the product accumulator.
    localparam int MAX_TERMS  = 32;
    localparam int MAX_DEGREE = 31;
    localparam int COEF_WIDTH = 16;

    // Fixed field widths of the ports.
    localparam int CMD_W     = 2;
    localparam int COEF_IN_W = 16;
    localparam int DEG_W     = 5;
    localparam int OUT_DEG_W = 6;
    localparam int ACC_W     = 42;

    // Derived sizes.
    localparam int SUM_W      = DEG_W + 1;
    localparam int ACC_DEPTH  = 2 * MAX_DEGREE + 1;
    localparam int ACC_ADDR_W = $clog2(ACC_DEPTH);
    localparam int IDX_W      = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W      = $clog2(MAX_TERMS + 1);
    localparam int TERM_W     = COEF_WIDTH + DEG_W;
    localparam int PROD_W     = 2 * COEF_WIDTH;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_LOAD_FIRST  = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_LOAD_SECOND = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_MULTIPLY    = CMD_W'(2);

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // Accumulator write request from the multiply-accumulate pipeline.
    typedef struct packed {
        logic                  en;
        logic [ACC_ADDR_W-1:0] addr;
        logic [ACC_W-1:0]      data;
    } acc_wr_t;

endpackage

>>> hdl/spm_ram.sv
module spm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/spm_mac.sv
module spm_mac (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           pair_valid,
    input  logic [spm_pkg::TERM_W-1:0]     a_term,
    input  logic [spm_pkg::TERM_W-1:0]     b_term,
    output logic [spm_pkg::ACC_ADDR_W-1:0] acc_rd_addr,
    input  logic [spm_pkg::ACC_W-1:0]      acc_rd_data,
    output logic [spm_pkg::ACC_ADDR_W-1:0] sum_deg,
    input  logic                           sum_touched,
    output spm_pkg::acc_wr_t               acc_wr,
    output logic                           busy
);

    import spm_pkg::*;

    logic [SUM_W-1:0]             deg_sum;
    logic                         deg_in_range;
    logic signed [COEF_WIDTH-1:0] a_coef;
    logic signed [COEF_WIDTH-1:0] b_coef;
    logic signed [PROD_W-1:0]     prod;

    logic                         p1_valid_reg;
    logic [ACC_ADDR_W-1:0]        p1_deg_reg;
    logic signed [PROD_W-1:0]     p1_prod_reg;

    logic                         fwd_valid_reg;
    logic [ACC_ADDR_W-1:0]        fwd_addr_reg;
    logic [ACC_W-1:0]             fwd_data_reg;

    logic [ACC_W-1:0]             base;
    logic [ACC_W-1:0]             prod_ext;

    // First stage: product of the two terms and the degree of the product.
    assign a_coef       = a_term[TERM_W-1:DEG_W];
    assign b_coef       = b_term[TERM_W-1:DEG_W];
    assign prod         = a_coef * b_coef;
    assign deg_sum      = SUM_W'(a_term[DEG_W-1:0]) + SUM_W'(b_term[DEG_W-1:0]);
    assign deg_in_range = deg_sum < SUM_W'(ACC_DEPTH);
    assign acc_rd_addr  = deg_sum[ACC_ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= pair_valid && deg_in_range;
        end
        p1_deg_reg  <= deg_sum[ACC_ADDR_W-1:0];
        p1_prod_reg <= prod;
    end

    // Second stage: read-modify-write of the accumulator cell. The write of the
    // previous cycle is not yet visible in the read data, so it is forwarded.
    // A cell that was never touched in this run counts as zero.
    assign prod_ext = ACC_W'(p1_prod_reg);

    always_comb begin
        if (fwd_valid_reg && (fwd_addr_reg == p1_deg_reg)) begin
            base = fwd_data_reg;
        end else if (sum_touched) begin
            base = acc_rd_data;
        end else begin
            base = '0;
        end
    end

    assign acc_wr.en   = p1_valid_reg;
    assign acc_wr.addr = p1_deg_reg;
    assign acc_wr.data = base + prod_ext;
    assign sum_deg     = p1_deg_reg;
    assign busy        = p1_valid_reg;

    // Copy of the last write for forwarding.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else begin
            fwd_valid_reg <= acc_wr.en;
        end
        fwd_addr_reg <= acc_wr.addr;
        fwd_data_reg <= acc_wr.data;
    end

endmodule

>>> hdl/sparse_polynomial_multiply.sv
// Sparse polynomial multiplier. Load items (command 0 or 1) write one term into
// the first or second term store; a load into a full store is dropped. A multiply
// item (command 2) walks every pair of stored terms, one pair per cycle through a
// single multiplier and a read-modify-write of the accumulator memory, and then
// waits for the pipeline to drain. The emit phase then scans the degrees in the
// order set by ascending_order, one degree per cycle, holding on a touched degree
// until the output register is free; each touched degree goes through the
// accumulator read and the output register. The last result carries last_term,
// and both stores are empty afterwards. Accumulator cells carry a touched bit in
// flip-flops, so no clearing pass is needed after reset.
module sparse_polynomial_multiply (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [spm_pkg::CMD_W-1:0]           s_command,
    input  logic signed [spm_pkg::COEF_IN_W-1:0] s_term_coef,
    input  logic [spm_pkg::DEG_W-1:0]           s_term_degree,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [spm_pkg::ACC_W-1:0]    m_product_coef,
    output logic [spm_pkg::OUT_DEG_W-1:0]       m_product_degree,
    output logic                                m_last_term
);

    import spm_pkg::*;

    state_t                state_reg, state_next;
    logic                  ascending_order_reg;
    logic [CNT_W-1:0]      first_count_reg, first_count_next;
    logic [CNT_W-1:0]      second_count_reg, second_count_next;
    logic [IDX_W-1:0]      i_reg, i_next;
    logic [IDX_W-1:0]      j_reg, j_next;
    logic [ACC_ADDR_W-1:0] k_reg, k_next;
    logic [ACC_DEPTH-1:0]  touched_reg, touched_next;
    logic                  pair_valid_reg, pair_valid_next;
    logic                  pend_reg, pend_next;
    logic [ACC_ADDR_W-1:0] pend_deg_reg, pend_deg_next;
    logic                  pend_last_reg, pend_last_next;

    logic                  m_valid_reg;
    logic [ACC_W-1:0]      m_coef_reg;
    logic [OUT_DEG_W-1:0]  m_deg_reg;
    logic                  m_last_reg;

    logic                  s_accept;
    logic                  deg_ok;
    logic                  first_we;
    logic                  second_we;
    logic [TERM_W-1:0]     term_word;
    logic [TERM_W-1:0]     a_term;
    logic [TERM_W-1:0]     b_term;

    logic [ACC_ADDR_W-1:0] mac_rd_addr;
    logic [ACC_ADDR_W-1:0] acc_rd_addr;
    logic [ACC_W-1:0]      acc_rd_data;
    logic [ACC_ADDR_W-1:0] sum_deg;
    acc_wr_t               acc_wr;
    logic                  mac_busy;

    logic                  last_i;
    logic                  last_j;
    logic [ACC_DEPTH-1:0]  touched_rest;
    logic                  emit_last;
    logic [ACC_ADDR_W-1:0] k_step;

    // Load decode.
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign deg_ok    = ({1'b0, s_term_degree} <= SUM_W'(MAX_DEGREE));
    assign first_we  = s_accept && (s_command == CMD_LOAD_FIRST) && deg_ok
                       && (first_count_reg != CNT_W'(MAX_TERMS));
    assign second_we = s_accept && (s_command == CMD_LOAD_SECOND) && deg_ok
                       && (second_count_reg != CNT_W'(MAX_TERMS));
    assign term_word = {s_term_coef[COEF_WIDTH-1:0], s_term_degree};

    // Term stores.
    spm_ram #(.WIDTH(TERM_W), .DEPTH(MAX_TERMS)) u_first_store (
        .aclk    (aclk),
        .wr_en   (first_we),
        .wr_addr (first_count_reg[IDX_W-1:0]),
        .wr_data (term_word),
        .rd_addr (i_reg),
        .rd_data (a_term)
    );

    spm_ram #(.WIDTH(TERM_W), .DEPTH(MAX_TERMS)) u_second_store (
        .aclk    (aclk),
        .wr_en   (second_we),
        .wr_addr (second_count_reg[IDX_W-1:0]),
        .wr_data (term_word),
        .rd_addr (j_reg),
        .rd_data (b_term)
    );

    // Accumulator memory, read by the pipeline while multiplying and by the
    // scanner while emitting.
    assign acc_rd_addr = (state_reg == ST_EMIT) ? k_reg : mac_rd_addr;

    spm_ram #(.WIDTH(ACC_W), .DEPTH(ACC_DEPTH)) u_accumulator (
        .aclk    (aclk),
        .wr_en   (acc_wr.en),
        .wr_addr (acc_wr.addr),
        .wr_data (acc_wr.data),
        .rd_addr (acc_rd_addr),
        .rd_data (acc_rd_data)
    );

    // Multiply-accumulate pipeline.
    spm_mac u_mac (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pair_valid  (pair_valid_reg),
        .a_term      (a_term),
        .b_term      (b_term),
        .acc_rd_addr (mac_rd_addr),
        .acc_rd_data (acc_rd_data),
        .sum_deg     (sum_deg),
        .sum_touched (touched_reg[sum_deg]),
        .acc_wr      (acc_wr),
        .busy        (mac_busy)
    );

    // Pair walk limits and the emit scan helpers.
    assign last_i       = (CNT_W'(i_reg) + CNT_W'(1)) == first_count_reg;
    assign last_j       = (CNT_W'(j_reg) + CNT_W'(1)) == second_count_reg;
    assign touched_rest = touched_reg & ~(ACC_DEPTH'(1) << k_reg);
    assign emit_last    = (touched_rest == '0);
    assign k_step       = ascending_order_reg ? (k_reg + ACC_ADDR_W'(1))
                                              : (k_reg - ACC_ADDR_W'(1));

    // Sequencer next state.
    always_comb begin
        state_next        = state_reg;
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        k_next            = k_reg;
        touched_next      = touched_reg;
        pair_valid_next   = 1'b0;
        pend_next         = 1'b0;
        pend_deg_next     = pend_deg_reg;
        pend_last_next    = pend_last_reg;

        if (acc_wr.en) begin
            touched_next[acc_wr.addr] = 1'b1;
        end

        case (state_reg)
            ST_IDLE: begin
                if (first_we) begin
                    first_count_next = first_count_reg + CNT_W'(1);
                end
                if (second_we) begin
                    second_count_next = second_count_reg + CNT_W'(1);
                end
                if (s_accept && (s_command == CMD_MULTIPLY)) begin
                    if ((first_count_reg == '0) || (second_count_reg == '0)) begin
                        first_count_next  = '0;
                        second_count_next = '0;
                    end else begin
                        state_next = ST_MUL;
                        i_next     = '0;
                        j_next     = '0;
                    end
                end
            end
            ST_MUL: begin
                pair_valid_next = 1'b1;
                if (last_j) begin
                    j_next = '0;
                    if (last_i) begin
                        first_count_next  = '0;
                        second_count_next = '0;
                        state_next        = ST_DRAIN;
                    end else begin
                        i_next = i_reg + IDX_W'(1);
                    end
                end else begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                if (!pair_valid_reg && !mac_busy) begin
                    state_next = ST_EMIT;
                    k_next     = ascending_order_reg ? '0 : ACC_ADDR_W'(ACC_DEPTH - 1);
                end
            end
            ST_EMIT: begin
                if (touched_reg == '0) begin
                    state_next = ST_IDLE;
                end else if (touched_reg[k_reg]) begin
                    if (!pend_reg && !m_valid_reg) begin
                        touched_next[k_reg] = 1'b0;
                        pend_next           = 1'b1;
                        pend_deg_next       = k_reg;
                        pend_last_next      = emit_last;
                        if (emit_last) begin
                            state_next = ST_IDLE;
                        end else begin
                            k_next = k_step;
                        end
                    end
                end else begin
                    k_next = k_step;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_IDLE;
            ascending_order_reg <= 1'b0;
            first_count_reg     <= '0;
            second_count_reg    <= '0;
            touched_reg         <= '0;
            pair_valid_reg      <= 1'b0;
            pend_reg            <= 1'b0;
        end else begin
            state_reg        <= state_next;
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            touched_reg      <= touched_next;
            pair_valid_reg   <= pair_valid_next;
            pend_reg         <= pend_next;
            if (cfg_wr_en) begin
                ascending_order_reg <= cfg_wr_data;
            end
        end
        i_reg         <= i_next;
        j_reg         <= j_next;
        k_reg         <= k_next;
        pend_deg_reg  <= pend_deg_next;
        pend_last_reg <= pend_last_next;
    end

    // Output register, loaded from the accumulator read in the cycle after the result is issued.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pend_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (pend_reg) begin
            m_coef_reg <= acc_rd_data;
            m_deg_reg  <= OUT_DEG_W'(pend_deg_reg);
            m_last_reg <= pend_last_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_product_coef   = m_coef_reg;
    assign m_product_degree = m_deg_reg;
    assign m_last_term      = m_last_reg;

`ifndef NO_ASSERTIONS
    // Store fill counts never pass the store depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (first_count_reg <= CNT_W'(MAX_TERMS)) && (second_count_reg <= CNT_W'(MAX_TERMS)))
        else $error("term store count exceeds the store depth");

    // The accumulator is written only during the pair walk and its drain.
    assert property (@(posedge aclk) disable iff (!aresetn)
        acc_wr.en |-> ((state_reg == ST_MUL) || (state_reg == ST_DRAIN)))
        else $error("accumulator written outside the multiply phase");

    // An issued accumulator read always lands in the output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |=> m_valid_reg)
        else $error("issued result did not reach the output register");

    // A result is issued only while the output register is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> !$past(m_valid_reg))
        else $error("result issued while the output register was occupied");

    // The scan ends once no touched degree remains.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_EMIT) && (touched_reg == '0)) |=> (state_reg == ST_IDLE))
        else $error("emit scan did not end with no touched degree left");
`endif

endmodule
